// ===== hw/rtl/sm4_pkg.sv =====
// Package for the SM4 block encryption core: word types, S-box, FK words,
// and the round helper functions. No dependencies.
`default_nettype none

package sm4_pkg;

	localparam int HALF_W    = 64;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 64;
	localparam int RND_W     = 5;

	typedef logic [31:0] word_t;
	typedef logic [3:0][31:0] quad_t;

	localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 2'd1;

	localparam logic [7:0] SBOX [256] = '{
		8'hD6,8'h90,8'hE9,8'hFE,8'hCC,8'hE1,8'h3D,8'hB7,8'h16,8'hB6,8'h14,8'hC2,8'h28,8'hFB,8'h2C,8'h05,
		8'h2B,8'h67,8'h9A,8'h76,8'h2A,8'hBE,8'h04,8'hC3,8'hAA,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
		8'h9C,8'h42,8'h50,8'hF4,8'h91,8'hEF,8'h98,8'h7A,8'h33,8'h54,8'h0B,8'h43,8'hED,8'hCF,8'hAC,8'h62,
		8'hE4,8'hB3,8'h1C,8'hA9,8'hC9,8'h08,8'hE8,8'h95,8'h80,8'hDF,8'h94,8'hFA,8'h75,8'h8F,8'h3F,8'hA6,
		8'h47,8'h07,8'hA7,8'hFC,8'hF3,8'h73,8'h17,8'hBA,8'h83,8'h59,8'h3C,8'h19,8'hE6,8'h85,8'h4F,8'hA8,
		8'h68,8'h6B,8'h81,8'hB2,8'h71,8'h64,8'hDA,8'h8B,8'hF8,8'hEB,8'h0F,8'h4B,8'h70,8'h56,8'h9D,8'h35,
		8'h1E,8'h24,8'h0E,8'h5E,8'h63,8'h58,8'hD1,8'hA2,8'h25,8'h22,8'h7C,8'h3B,8'h01,8'h21,8'h78,8'h87,
		8'hD4,8'h00,8'h46,8'h57,8'h9F,8'hD3,8'h27,8'h52,8'h4C,8'h36,8'h02,8'hE7,8'hA0,8'hC4,8'hC8,8'h9E,
		8'hEA,8'hBF,8'h8A,8'hD2,8'h40,8'hC7,8'h38,8'hB5,8'hA3,8'hF7,8'hF2,8'hCE,8'hF9,8'h61,8'h15,8'hA1,
		8'hE0,8'hAE,8'h5D,8'hA4,8'h9B,8'h34,8'h1A,8'h55,8'hAD,8'h93,8'h32,8'h30,8'hF5,8'h8C,8'hB1,8'hE3,
		8'h1D,8'hF6,8'hE2,8'h2E,8'h82,8'h66,8'hCA,8'h60,8'hC0,8'h29,8'h23,8'hAB,8'h0D,8'h53,8'h4E,8'h6F,
		8'hD5,8'hDB,8'h37,8'h45,8'hDE,8'hFD,8'h8E,8'h2F,8'h03,8'hFF,8'h6A,8'h72,8'h6D,8'h6C,8'h5B,8'h51,
		8'h8D,8'h1B,8'hAF,8'h92,8'hBB,8'hDD,8'hBC,8'h7F,8'h11,8'hD9,8'h5C,8'h41,8'h1F,8'h10,8'h5A,8'hD8,
		8'h0A,8'hC1,8'h31,8'h88,8'hA5,8'hCD,8'h7B,8'hBD,8'h2D,8'h74,8'hD0,8'h12,8'hB8,8'hE5,8'hB4,8'hB0,
		8'h89,8'h69,8'h97,8'h4A,8'h0C,8'h96,8'h77,8'h7E,8'h65,8'hB9,8'hF1,8'h09,8'hC5,8'h6E,8'hC6,8'h84,
		8'h18,8'hF0,8'h7D,8'hEC,8'h3A,8'hDC,8'h4D,8'h20,8'h79,8'hEE,8'h5F,8'h3E,8'hD7,8'hCB,8'h39,8'h48
	};

	localparam word_t FK [4] = '{32'hA3B1BAC6, 32'h56AA3350, 32'h677D9197, 32'hB27022DC};

	function automatic word_t subst(word_t v);
		return {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
	endfunction

	function automatic word_t rotl(word_t v, int unsigned n);
		return (v << n) | (v >> (32 - n));
	endfunction

	function automatic word_t lin_data(word_t b);
		return b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
	endfunction

	function automatic word_t lin_key(word_t b);
		return b ^ rotl(b, 13) ^ rotl(b, 23);
	endfunction

	// Byte j of CK word i is ((4*i + j) * 7) mod 256, most significant byte first.
	function automatic word_t ck_word(logic [RND_W-1:0] i);
		word_t w;
		logic [7:0] idx;
		int j;
		w = '0;
		for (j = 0; j < 4; j++) begin
			idx = {1'b0, i, 2'(j)};
			w = {w[23:0], 8'(idx * 8'd7)};
		end
		return w;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/sm4_if.sv =====
// Valid/ready stream interfaces for the plaintext and ciphertext channels.
// Depends on sm4_pkg for the field width.
`default_nettype none

interface sm4_in_if;
	import sm4_pkg::*;
	logic              valid;
	logic              ready;
	logic [HALF_W-1:0] plain_high;
	logic [HALF_W-1:0] plain_low;
	modport source (output valid, plain_high, plain_low, input ready);
	modport sink (input valid, plain_high, plain_low, output ready);
endinterface

interface sm4_out_if;
	import sm4_pkg::*;
	logic              valid;
	logic              ready;
	logic [HALF_W-1:0] cipher_high;
	logic [HALF_W-1:0] cipher_low;
	modport source (output valid, cipher_high, cipher_low, input ready);
	modport sink (input valid, cipher_high, cipher_low, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/sm4_round.sv =====
// Shared SM4 round function used for both key expansion and encryption.
// Depends on sm4_pkg for the S-box and the two linear transforms.
`default_nettype none

module sm4_round (
	input  sm4_pkg::quad_t w,
	input  sm4_pkg::word_t rk,
	input  logic           key_mode,
	output sm4_pkg::word_t nx
);
	import sm4_pkg::*;

	word_t mix;
	word_t sub;

	assign mix = w[1] ^ w[2] ^ w[3] ^ rk;
	assign sub = subst(mix);
	assign nx  = w[0] ^ (key_mode ? lin_key(sub) : lin_data(sub));

endmodule

`default_nettype wire

// ===== hw/rtl/sm4_block_encrypt_core.sv =====
// SM4 block encryption core: key registers, round key store and sequencer
// around one shared round unit. Depends on sm4_pkg, sm4_if and sm4_round.
//
// channel   | dir | transfer carries
// ----------+-----+------------------------------------------
// blk_in    | in  | plain_high, plain_low (X0..X3)
// blk_out   | out | cipher_high, cipher_low (X35..X32)
// cfg       | in  | cfg_wr_en, cfg_idx, cfg_wdata (key halves)
//
// A block is loaded on its input transfer, runs 32 rounds through the single
// round unit, and is written to the output register before blk_in is ready
// for the next one. After reset and after each key write, key expansion (a
// load step and 32 rounds) runs on the same round unit before blk_in is ready.
// A result waiting on blk_out holds the next finished block until it is taken.
`default_nettype none

module sm4_block_encrypt_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [sm4_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [sm4_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	sm4_in_if.sink                             blk_in,
	sm4_out_if.source                          blk_out
);
	import sm4_pkg::*;

	localparam logic [2:0] ST_KLOAD = 3'd0;
	localparam logic [2:0] ST_KEXP  = 3'd1;
	localparam logic [2:0] ST_IDLE  = 3'd2;
	localparam logic [2:0] ST_DATA  = 3'd3;
	localparam logic [2:0] ST_DRAIN = 3'd4;

	logic [2:0]        state_q;
	logic [RND_W-1:0]  rnd_q;
	logic [HALF_W-1:0] key_high_q;
	logic [HALF_W-1:0] key_low_q;
	quad_t             words_q;
	word_t             rk_q [32];
	logic              out_valid_q;
	logic [HALF_W-1:0] cipher_high_q;
	logic [HALF_W-1:0] cipher_low_q;

	logic  key_wr;
	logic  in_xfer;
	logic  out_free;
	logic  last_rnd;
	logic  key_mode;
	word_t rk_sel;
	word_t nx;

	assign key_wr   = cfg_wr_en && (cfg_idx == REG_KEY_HIGH || cfg_idx == REG_KEY_LOW);
	assign in_xfer  = blk_in.valid && blk_in.ready;
	assign out_free = !out_valid_q || blk_out.ready;
	assign last_rnd = (rnd_q == RND_W'(31));
	assign key_mode = (state_q == ST_KEXP);
	assign rk_sel   = key_mode ? ck_word(rnd_q) : rk_q[rnd_q];

	assign blk_in.ready        = (state_q == ST_IDLE) && !key_wr;
	assign blk_out.valid       = out_valid_q;
	assign blk_out.cipher_high = cipher_high_q;
	assign blk_out.cipher_low  = cipher_low_q;

	sm4_round u_round (
		.w        (words_q),
		.rk       (rk_sel),
		.key_mode (key_mode),
		.nx       (nx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_KLOAD;
			rnd_q       <= '0;
			key_high_q  <= '0;
			key_low_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (key_wr) begin
				if (cfg_idx == REG_KEY_HIGH) begin
					key_high_q <= cfg_wdata;
				end else begin
					key_low_q <= cfg_wdata;
				end
			end

			if (state_q == ST_DRAIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (blk_out.ready) begin
				out_valid_q <= 1'b0;
			end

			if (key_wr) begin
				state_q <= ST_KLOAD;
				rnd_q   <= '0;
			end else begin
				unique case (state_q)
					ST_KLOAD: begin
						state_q <= ST_KEXP;
						rnd_q   <= '0;
					end
					ST_KEXP: begin
						rnd_q <= rnd_q + RND_W'(1);
						if (last_rnd) begin
							state_q <= ST_IDLE;
						end
					end
					ST_IDLE: begin
						if (in_xfer) begin
							state_q <= ST_DATA;
							rnd_q   <= '0;
						end
					end
					ST_DATA: begin
						rnd_q <= rnd_q + RND_W'(1);
						if (last_rnd) begin
							state_q <= ST_DRAIN;
						end
					end
					ST_DRAIN: begin
						if (out_free) begin
							state_q <= ST_IDLE;
						end
					end
					default: begin
						state_q <= ST_KLOAD;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_KLOAD: begin
				words_q <= {key_low_q[31:0] ^ FK[3], key_low_q[63:32] ^ FK[2],
					key_high_q[31:0] ^ FK[1], key_high_q[63:32] ^ FK[0]};
			end
			ST_KEXP: begin
				rk_q[rnd_q] <= nx;
				words_q     <= {nx, words_q[3:1]};
			end
			ST_IDLE: begin
				if (in_xfer) begin
					words_q <= {blk_in.plain_low[31:0], blk_in.plain_low[63:32],
						blk_in.plain_high[31:0], blk_in.plain_high[63:32]};
				end
			end
			ST_DATA: begin
				words_q <= {nx, words_q[3:1]};
			end
			ST_DRAIN: begin
				if (out_free) begin
					cipher_high_q <= {words_q[3], words_q[2]};
					cipher_low_q  <= {words_q[1], words_q[0]};
				end
			end
			default: begin
				words_q <= words_q;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== hw/rtl/sm4_checker.sv =====
// Port-level checks for the SM4 encryption core, attached by bind.
// Depends on sm4_pkg for the port widths and the key register indices.
`default_nettype none

module sm4_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           cfg_wr_en,
	input logic [sm4_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input logic                           in_valid,
	input logic                           in_ready,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic [sm4_pkg::HALF_W-1:0]     out_high,
	input logic [sm4_pkg::HALF_W-1:0]     out_low
);
	import sm4_pkg::*;

	// A waiting result stays offered and unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_high) && $stable(out_low))
		else $error("result changed while stalled");

	// A key write starts a new key expansion, so no block is taken next cycle.
	a_key_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr_en && (cfg_idx == REG_KEY_HIGH || cfg_idx == REG_KEY_LOW) |=> !in_ready)
		else $error("input ready right after a key write");

	// One block at a time: after a transfer in, the input is closed.
	a_one_block: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second block taken while busy");

	// The rounds run between a transfer in and its result, so no result appears right after a transfer in.
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result appeared too early");

endmodule

bind sm4_block_encrypt_core sm4_checker u_sm4_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cfg_wr_en (cfg_wr_en),
	.cfg_idx   (cfg_idx),
	.in_valid  (blk_in.valid),
	.in_ready  (blk_in.ready),
	.out_valid (blk_out.valid),
	.out_ready (blk_out.ready),
	.out_high  (blk_out.cipher_high),
	.out_low   (blk_out.cipher_low)
);

`default_nettype wire
